/* rtl/core/cbatc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbatc_pkg
// Shared types, widths and constants for the block-averaged,
// temperature-compensated conductivity unit.
// ----------------------------------------------------------------------------
package cbatc_pkg;

   localparam int SAMPLE_W = 16;
   localparam int TEMP_W   = 16;
   localparam int OUT_W    = 16;
   localparam int SUM_W    = 24;
   localparam int CNT_W    = 8;
   localparam int CC_W     = 24;
   localparam int COEF_W   = 16;
   localparam int REF_W    = 14;
   localparam int SCALE_W  = 7;
   localparam int K_W      = CC_W + SCALE_W;
   localparam int NUM_W    = SUM_W + K_W;
   localparam int DEN_W    = 35;
   localparam int DMAG_W   = 33;
   localparam int CSR_W    = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [SCALE_W-1:0]  CENTI_SCALE   = 7'd100;
   localparam logic [DEN_W-1:0]    Q16_TIMES_100 = 35'd6553600;
   localparam logic [OUT_W-1:0]    OUT_MAX       = 16'hFFFF;

   localparam logic [CNT_W-1:0]    BLOCK_LENGTH_RST = 8'd5;
   localparam logic [CC_W-1:0]     CELL_CONST_RST   = 24'd337110;
   localparam logic [COEF_W-1:0]   TEMP_COEFF_RST   = 16'd1376;
   localparam logic [REF_W-1:0]    REF_TEMP_RST     = 14'd2500;

   typedef enum logic [CSR_W-1:0] {
      CSR_BLOCK_LENGTH = 2'd0,
      CSR_CELL_CONSTANT = 2'd1,
      CSR_TEMP_COEFF = 2'd2,
      CSR_REF_TEMP = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] raw_sample;
      logic [TEMP_W-1:0]   temp_centi;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] compensated;
      logic             saturated;
   } rsp_type;

endpackage
`default_nettype wire

/* rtl/core/cbatc_mean_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbatc_mean_div
// Bit-serial restoring divider: block sum over sample count, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module cbatc_mean_div
   import cbatc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output logic                  done,
   output logic [SUM_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dsr_ff;
   logic [CNT_W+1:0]  trial;
   logic              qbit;

   assign trial = {1'b0, rem_ff, quo_ff[SUM_W-1]} - {2'b00, dsr_ff};
   assign qbit  = ~trial[CNT_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = qbit ? trial[CNT_W-1:0] : {rem_ff[CNT_W-2:0], quo_ff[SUM_W-1]};
      quo_in  = {quo_ff[SUM_W-2:0], qbit};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

/* rtl/core/cbatc_serial_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbatc_serial_mul
// Shift-add multiplier: mean times scaled cell constant, one multiplier bit
// per cycle, LSB first.
// ----------------------------------------------------------------------------
module cbatc_serial_mul
   import cbatc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] multiplier,
   input  wire logic [K_W-1:0]   multiplicand,
   output logic                  done,
   output logic [NUM_W-1:0]      product
);

   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [K_W-1:0]    acc_ff, acc_in;
   logic [SUM_W-1:0]  mier_ff, mier_in;
   logic [K_W-1:0]    mcand_ff;
   logic [K_W:0]      psum;

   assign psum    = {1'b0, acc_ff} + (mier_ff[0] ? {1'b0, mcand_ff} : '0);
   assign acc_in  = psum[K_W:1];
   assign mier_in = {psum[0], mier_ff[SUM_W-1:1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff   <= '0;
         mier_ff  <= multiplier;
         mcand_ff <= multiplicand;
      end else if (busy_ff) begin
         acc_ff  <= acc_in;
         mier_ff <= mier_in;
      end
   end

   assign done    = done_ff;
   assign product = {acc_ff, mier_ff};

endmodule
`default_nettype wire

/* rtl/core/cbatc_quot_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbatc_quot_div
// Saturating bit-serial divider: scaled numerator over compensation
// denominator, overflow check up front, then one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbatc_quot_div
   import cbatc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  numer,
   input  wire logic [DMAG_W-1:0] denom,
   output logic                   done,
   output rsp_type                result
);

   localparam int STEP_W = $clog2(OUT_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(OUT_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DMAG_W-1:0] rem_ff, rem_in;
   logic [OUT_W-1:0]  quo_ff, quo_in;
   logic [DMAG_W-1:0] dsr_ff;
   logic              sat_ff;
   logic              over;
   logic [DMAG_W+1:0] trial;
   logic              qbit;

   assign over  = numer[NUM_W-1:OUT_W] >= (NUM_W-OUT_W)'(denom);
   assign trial = {1'b0, rem_ff, quo_ff[OUT_W-1]} - {2'b00, dsr_ff};
   assign qbit  = ~trial[DMAG_W+1];
   assign rem_in = qbit ? trial[DMAG_W-1:0] : {rem_ff[DMAG_W-2:0], quo_ff[OUT_W-1]};
   assign quo_in = {quo_ff[OUT_W-2:0], qbit};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      if (start) begin
         step_in = '0;
         if (over) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= numer[OUT_W+DMAG_W-1:OUT_W];
         quo_ff <= numer[OUT_W-1:0];
         dsr_ff <= denom;
         sat_ff <= over;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done               = done_ff;
   assign result.compensated = sat_ff ? OUT_MAX : quo_ff;
   assign result.saturated   = sat_ff;

endmodule
`default_nettype wire

/* rtl/core/conductivity_block_average_temp_comp_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// conductivity_block_average_temp_comp_unit
// Block-averaged conductivity with linear temperature compensation.
// ----------------------------------------------------------------------------
// A request that does not close a block is added to the block sum and count,
// gives no response and leaves the unit ready. The request that closes a block
// starts three bit-serial units in turn: the mean divider, the shift-add
// multiplier and the saturating quotient divider, which skips its serial steps
// on overflow and is not started for a denominator that is not positive. The
// next request is taken once the response is in the output register. A pending
// response does not hold off requests that do not close a block.
// ----------------------------------------------------------------------------
module conductivity_block_average_temp_comp_unit
   import cbatc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire csr_index_type         csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_MUL,
      ST_QUOT,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [CNT_W-1:0]  blen_ff;
   logic [CC_W-1:0]   cc_ff;
   logic [COEF_W-1:0] coeff_ff;
   logic [REF_W-1:0]  ref_ff;

   logic signed [DEN_W-1:0] prod_ff, prod_in;
   logic signed [DEN_W-1:0] den_ff, den_in;
   logic signed [DEN_W-1:0] diff_ext, coef_ext;
   logic [K_W-1:0]    k_ff, k_in;
   rsp_type           res_ff;
   rsp_type           rsp_data_ff;

   logic              accept, closes, den_pos, load_rsp;
   logic [SUM_W-1:0]  sum_next;
   logic [CNT_W-1:0]  n_next, len;

   logic              mean_done, mul_done, quot_done;
   logic              mul_start, quot_start;
   logic [SUM_W-1:0]  mean;
   logic [NUM_W-1:0]  numer;
   rsp_type           quot_result;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign sum_next  = sum_ff + SUM_W'(req_data.raw_sample);
   assign n_next    = count_ff + 1'b1;
   assign len       = (blen_ff == '0) ? CNT_W'(1) : blen_ff;
   assign closes    = (n_next >= len);

   assign diff_ext = $signed({{(DEN_W-TEMP_W){1'b0}}, req_data.temp_centi})
                   - $signed({{(DEN_W-REF_W){1'b0}}, ref_ff});
   assign coef_ext = $signed({{(DEN_W-COEF_W){1'b0}}, coeff_ff});
   assign prod_in  = diff_ext * coef_ext;
   assign den_in   = $signed(Q16_TIMES_100) + prod_ff;
   assign den_pos  = ~den_ff[DEN_W-1] && (den_ff != '0);
   assign k_in     = K_W'(cc_ff) * K_W'(CENTI_SCALE);

   assign mul_start  = (state_ff == ST_MEAN) && mean_done;
   assign quot_start = (state_ff == ST_MUL) && mul_done && den_pos;
   assign load_rsp   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   cbatc_mean_div u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && closes),
      .dividend (sum_next),
      .divisor  (n_next),
      .done     (mean_done),
      .quotient (mean)
   );

   cbatc_serial_mul u_serial_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplier   (mean),
      .multiplicand (k_ff),
      .done         (mul_done),
      .product      (numer)
   );

   cbatc_quot_div u_quot_div (
      .clock  (clock),
      .reset  (reset),
      .start  (quot_start),
      .numer  (numer),
      .denom  (den_ff[DMAG_W-1:0]),
      .done   (quot_done),
      .result (quot_result)
   );

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (closes) begin
                  sum_in   = '0;
                  count_in = '0;
                  state_in = ST_MEAN;
               end else begin
                  sum_in   = sum_next;
                  count_in = n_next;
               end
            end
         end
         ST_MEAN: begin
            if (mean_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = den_pos ? ST_QUOT : ST_DONE;
            end
         end
         ST_QUOT: begin
            if (quot_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blen_ff  <= BLOCK_LENGTH_RST;
         cc_ff    <= CELL_CONST_RST;
         coeff_ff <= TEMP_COEFF_RST;
         ref_ff   <= REF_TEMP_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BLOCK_LENGTH:  blen_ff  <= csr_wdata[CNT_W-1:0];
            CSR_CELL_CONSTANT: cc_ff    <= csr_wdata[CC_W-1:0];
            CSR_TEMP_COEFF:    coeff_ff <= csr_wdata[COEF_W-1:0];
            CSR_REF_TEMP:      ref_ff   <= csr_wdata[REF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && closes) begin
         prod_ff <= prod_in;
         k_ff    <= k_in;
      end
      if (state_ff == ST_MEAN) begin
         den_ff <= den_in;
      end
      if ((state_ff == ST_MUL) && mul_done && !den_pos) begin
         res_ff.compensated <= OUT_MAX;
         res_ff.saturated   <= 1'b1;
      end else if ((state_ff == ST_QUOT) && quot_done) begin
         res_ff <= quot_result;
      end
      if (load_rsp) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

/* tb/sv/conductivity_block_average_temp_comp_unit_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// conductivity_block_average_temp_comp_unit_tb
// Drives raw samples and cell temperatures into the unit, tracks the running
// block sum and the register settings, and predicts the block means after
// cell constant scaling and linear temperature compensation. A short table,
// some of whose rows give their expected result, covers the corner settings,
// and random phases with changing sender and receiver stalls follow.
// ----------------------------------------------------------------------------
module conductivity_block_average_temp_comp_unit_tb;
   import cbatc_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 100;
   localparam int PHASES        = 12;
   localparam int WIDE_PHASE    = 6;
   localparam int PHASE_ITEMS   = 85;
   localparam int WIDE_ITEMS    = 260;

   typedef struct {
      bit                    is_write;
      csr_index_type         index;
      logic [CSR_DATA_W-1:0] value;
      req_type               sample;
      bit                    typed;
      rsp_type               golden;
   } plan_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   csr_index_type         csr_index = CSR_BLOCK_LENGTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [CNT_W-1:0]  len_setting = BLOCK_LENGTH_RST;
   logic [CC_W-1:0]   cell_k      = CELL_CONST_RST;
   logic [COEF_W-1:0] coeff_k     = TEMP_COEFF_RST;
   logic [REF_W-1:0]  ref_centi   = REF_TEMP_RST;
   logic [SUM_W-1:0]  block_sum   = '0;
   logic [CNT_W-1:0]  block_count = '0;

   rsp_type      pending_readings [$];
   plan_row_type plan [$];
   int           mismatches   = 0;
   int           src_idle_pct = 15;
   int           snk_idle_pct = 86;
   bit           row_typed    = 1'b0;
   rsp_type      row_golden   = '0;

   conductivity_block_average_temp_comp_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= snk_idle_pct);
   end

   function automatic rsp_type compensate(logic [SUM_W-1:0] total, logic [CNT_W:0] n,
                                          logic [TEMP_W-1:0] temp);
      longint          den, t, rf, k;
      longint unsigned mean, numer, quot;
      rsp_type         r;
      mean = total / n;
      t = temp;
      rf = ref_centi;
      k = coeff_k;
      den = Q16_TIMES_100;
      den = den + (t - rf) * k;
      r.compensated = OUT_MAX;
      r.saturated = 1'b1;
      if (den > 0) begin
         numer = mean * cell_k * CENTI_SCALE;
         quot = numer / den;
         if (quot <= OUT_MAX) begin
            r.compensated = quot[OUT_W-1:0];
            r.saturated = 1'b0;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      logic [CNT_W:0] span, n;
      rsp_type        want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_readings.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response: expected none, actual %0d/%0d",
                        $time, rsp_data.compensated, rsp_data.saturated);
            end else begin
               want = pending_readings.pop_front();
               if (rsp_data.compensated !== want.compensated) begin
                  mismatches++;
                  $display("%0t: compensated: expected %0d, actual %0d",
                           $time, want.compensated, rsp_data.compensated);
               end
               if (rsp_data.saturated !== want.saturated) begin
                  mismatches++;
                  $display("%0t: saturated: expected %0d, actual %0d",
                           $time, want.saturated, rsp_data.saturated);
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_BLOCK_LENGTH:  len_setting = csr_wdata[CNT_W-1:0];
               CSR_CELL_CONSTANT: cell_k = csr_wdata[CC_W-1:0];
               CSR_TEMP_COEFF:    coeff_k = csr_wdata[COEF_W-1:0];
               CSR_REF_TEMP:      ref_centi = csr_wdata[REF_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            span = (len_setting == '0) ? (CNT_W+1)'(1) : {1'b0, len_setting};
            block_sum = block_sum + req_data.raw_sample;
            n = {1'b0, block_count} + 1'b1;
            if (n < span) begin
               block_count = n[CNT_W-1:0];
            end else begin
               pending_readings.push_back(row_typed ? row_golden
                                          : compensate(block_sum, n, req_data.temp_centi));
               block_sum = '0;
               block_count = '0;
            end
         end
      end
   end

   function automatic plan_row_type write_row(csr_index_type idx, int v);
      plan_row_type r;
      r.is_write = 1'b1;
      r.index = idx;
      r.value = CSR_DATA_W'(v);
      r.sample = '0;
      r.typed = 1'b0;
      r.golden = '0;
      return r;
   endfunction

   function automatic plan_row_type sample_row(int raw, int temp, int typed, int comp,
                                               int sat);
      plan_row_type r;
      r.is_write = 1'b0;
      r.index = CSR_BLOCK_LENGTH;
      r.value = '0;
      r.sample.raw_sample = SAMPLE_W'(raw);
      r.sample.temp_centi = TEMP_W'(temp);
      r.typed = (typed != 0);
      r.golden.compensated = OUT_W'(comp);
      r.golden.saturated = (sat != 0);
      return r;
   endfunction

   function automatic int pick_setting(int lo, int hi, int span_lo, int span_hi);
      case ($urandom_range(7))
         0: return lo;
         1: return hi;
         default: return $urandom_range(span_hi, span_lo);
      endcase
   endfunction

   function automatic req_type random_sample();
      req_type s;
      int      t;
      case ($urandom_range(3))
         0: s.raw_sample = SAMPLE_W'($urandom_range(65535));
         1: s.raw_sample = SAMPLE_W'($urandom_range(4095));
         default: s.raw_sample = SAMPLE_W'($urandom_range(16383));
      endcase
      if ($urandom_range(3) == 0) begin
         s.temp_centi = TEMP_W'($urandom_range(65535));
      end else begin
         t = int'(ref_centi) + int'($urandom_range(6000)) - 3000;
         if (t < 0) t = 0;
         s.temp_centi = TEMP_W'(t);
      end
      return s;
   endfunction

   task automatic send_sample(req_type s);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic put_reg(csr_index_type idx, int v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(v);
      @(negedge clock);
   endtask

   initial begin
      bit writing;
      int count;
      writing = 1'b0;

      plan.push_back(sample_row(65535, 0, 0, 0, 0));
      plan.push_back(sample_row(0, 65535, 0, 0, 0));
      plan.push_back(sample_row(1, 2500, 0, 0, 0));
      plan.push_back(sample_row(65535, 65535, 0, 0, 0));
      plan.push_back(sample_row(12345, 2499, 0, 0, 0));
      plan.push_back(write_row(CSR_BLOCK_LENGTH, 1));
      plan.push_back(sample_row(0, 2500, 1, 0, 0));
      plan.push_back(sample_row(65535, 0, 1, OUT_MAX, 1));
      plan.push_back(sample_row(65535, 65535, 0, 0, 0));
      plan.push_back(write_row(CSR_TEMP_COEFF, 32768));
      plan.push_back(write_row(CSR_REF_TEMP, 200));
      plan.push_back(sample_row(0, 0, 1, OUT_MAX, 1));
      plan.push_back(sample_row(40000, 1, 0, 0, 0));
      plan.push_back(write_row(CSR_TEMP_COEFF, 65535));
      plan.push_back(write_row(CSR_REF_TEMP, 10000));
      plan.push_back(sample_row(5, 0, 1, OUT_MAX, 1));
      plan.push_back(sample_row(5, 65535, 0, 0, 0));
      plan.push_back(write_row(CSR_CELL_CONSTANT, 65536));
      plan.push_back(write_row(CSR_TEMP_COEFF, 0));
      plan.push_back(write_row(CSR_BLOCK_LENGTH, 3));
      plan.push_back(sample_row(1, 43690, 0, 0, 0));
      plan.push_back(sample_row(2, 21845, 0, 0, 0));
      plan.push_back(sample_row(4, 4660, 1, 2, 0));
      plan.push_back(write_row(CSR_BLOCK_LENGTH, 0));
      plan.push_back(sample_row(777, 123, 1, 777, 0));
      plan.push_back(write_row(CSR_BLOCK_LENGTH, 5));
      plan.push_back(sample_row(10, 9000, 0, 0, 0));
      plan.push_back(sample_row(20, 51966, 0, 0, 0));
      plan.push_back(sample_row(31, 30000, 0, 0, 0));
      plan.push_back(write_row(CSR_BLOCK_LENGTH, 2));
      plan.push_back(sample_row(39, 2500, 1, 25, 0));
      plan.push_back(write_row(CSR_CELL_CONSTANT, 16777215));
      plan.push_back(write_row(CSR_BLOCK_LENGTH, 1));
      plan.push_back(sample_row(1, 2500, 1, 255, 0));
      plan.push_back(sample_row(65535, 2500, 1, OUT_MAX, 1));
      plan.push_back(write_row(CSR_CELL_CONSTANT, 0));
      plan.push_back(sample_row(65535, 2500, 1, 0, 0));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            if (!writing) begin
               settle();
               writing = 1'b1;
            end
            put_reg(plan[i].index, int'(plan[i].value));
         end else begin
            if (writing) begin
               csr_we <= 1'b0;
               writing = 1'b0;
            end
            row_typed = plan[i].typed;
            row_golden = plan[i].golden;
            send_sample(plan[i].sample);
         end
      end
      row_typed = 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 4) begin
            src_idle_pct = 15;
            snk_idle_pct = 86;
         end else if (ph < 8) begin
            src_idle_pct = 86;
            snk_idle_pct = 15;
         end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
         end
         settle();
         if (ph == WIDE_PHASE) begin
            put_reg(CSR_BLOCK_LENGTH, 255);
            put_reg(CSR_CELL_CONSTANT, 16777215);
            put_reg(CSR_TEMP_COEFF, 65535);
            put_reg(CSR_REF_TEMP, 0);
            count = WIDE_ITEMS;
         end else begin
            put_reg(CSR_BLOCK_LENGTH, pick_setting(0, 255, 1, 8));
            put_reg(CSR_CELL_CONSTANT, pick_setting(0, 16777215, 20000, 700000));
            put_reg(CSR_TEMP_COEFF, pick_setting(0, 65535, 0, 4000));
            put_reg(CSR_REF_TEMP, pick_setting(0, 10000, 0, 10000));
            count = PHASE_ITEMS;
         end
         csr_we <= 1'b0;
         repeat (count) send_sample(random_sample());
      end

      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire

/* files.f */
rtl/core/cbatc_pkg.sv
rtl/core/cbatc_mean_div.sv
rtl/core/cbatc_serial_mul.sv
rtl/core/cbatc_quot_div.sv
rtl/core/conductivity_block_average_temp_comp_unit.sv
tb/sv/conductivity_block_average_temp_comp_unit_tb.sv
